@@ design/bsc_pkg.sv @@
// ----------------------------------------------------------------------------
// bsc_pkg: shared types and constants of the safety check
// Function codes, command beat layout, queue status and back-end states.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int MAX_PROCS_DEF = 8;
    localparam int RESOURCES_DEF = 4;
    localparam int LANES         = 4;
    localparam int AMT_W         = 8;
    localparam int IDX_W         = 3;
    localparam int FUNC_W        = 2;
    localparam int PROCS_W       = 4;
    localparam int SEQ_W         = 3;
    localparam int WORK_W        = 12;
    localparam int CMDQ_DEPTH    = 4;

    localparam logic [WORK_W-1:0]  WORK_MAX    = {WORK_W{1'b1}};
    localparam logic [PROCS_W-1:0] PROCS_RESET = 4'd8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_AVAIL = 2'd0,
        FUNC_ROW   = 2'd1,
        FUNC_CHECK = 2'd2
    } t_func;

    typedef struct packed {
        t_func                       op;
        logic [IDX_W-1:0]            idx;
        logic [LANES-1:0][AMT_W-1:0] amount;
        logic [LANES-1:0][AMT_W-1:0] claim;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmdq_wr;

    typedef struct packed {
        logic empty;
        logic full;
    } t_cmdq_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_EMIT
    } t_back_state;

    // Add an allocation to a working sum, clamp at the top of the range.
    function automatic logic [WORK_W-1:0] sat_add(input logic [WORK_W-1:0] work,
                                                  input logic [AMT_W-1:0]  amt);
        logic [WORK_W:0] sum;
        sum = {1'b0, work} + {{(WORK_W+1-AMT_W){1'b0}}, amt};
        return sum[WORK_W] ? WORK_MAX : sum[WORK_W-1:0];
    endfunction

endpackage

@@ design/bsc_front.sv @@
// ----------------------------------------------------------------------------
// bsc_front: input side of the safety check
// Accepts item beats, drops unknown functions and out-of-range row loads,
// and forwards the rest as command beats to the command queue.
// ----------------------------------------------------------------------------
module bsc_front #(
    parameter int MAX_PROCS = bsc_pkg::MAX_PROCS_DEF
) (
    input  logic                                              push,
    input  bsc_pkg::t_cmdq_status                             i_q_status,
    input  logic [bsc_pkg::FUNC_W-1:0]                        i_func,
    input  logic [bsc_pkg::IDX_W-1:0]                         i_proc_index,
    input  logic [bsc_pkg::LANES-1:0][bsc_pkg::AMT_W-1:0]     i_amount,
    input  logic [bsc_pkg::LANES-1:0][bsc_pkg::AMT_W-1:0]     i_claim,
    output bsc_pkg::t_cmdq_wr                                 o_wr
);

    logic w_accept;
    logic w_keep;

    assign w_accept = push && !i_q_status.full;

    // Classify the beat: keep loads of a real row, the avail load and checks
    always_comb begin
        case (bsc_pkg::t_func'(i_func))
            bsc_pkg::FUNC_AVAIL: w_keep = 1'b1;
            bsc_pkg::FUNC_ROW:   w_keep = ({29'd0, i_proc_index} < 32'(MAX_PROCS));
            bsc_pkg::FUNC_CHECK: w_keep = 1'b1;
            default:             w_keep = 1'b0;
        endcase
    end

    // Build the command beat
    always_comb begin
        o_wr.valid      = w_accept && w_keep;
        o_wr.cmd.op     = bsc_pkg::t_func'(i_func);
        o_wr.cmd.idx    = i_proc_index;
        o_wr.cmd.amount = i_amount;
        o_wr.cmd.claim  = i_claim;
    end

endmodule

@@ design/bsc_cmd_queue.sv @@
// ----------------------------------------------------------------------------
// bsc_cmd_queue: command queue between front and back
// Small FIFO of command beats so the front keeps taking items while the
// back walks a check.
// ----------------------------------------------------------------------------
module bsc_cmd_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bsc_pkg::t_cmdq_wr     i_wr,
    input  logic                  i_pop,
    output bsc_pkg::t_cmd         o_head,
    output bsc_pkg::t_cmdq_status o_status
);

    localparam int DEPTH = bsc_pkg::CMDQ_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsc_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             w_do_pop;

    assign w_do_pop = i_pop && (r_cnt != '0);

    // Advance pointers and fill count
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (i_wr.valid) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (i_wr.valid && !w_do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (!i_wr.valid && w_do_pop) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // Store the beat
    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            r_mem[r_wr_ptr] <= i_wr.cmd;
        end
    end

    assign o_head         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_cnt == '0);
    assign o_status.full  = (r_cnt == CNT_W'(DEPTH));

endmodule

@@ design/bsc_back.sv @@
// ----------------------------------------------------------------------------
// bsc_back: execution side of the safety check
// Holds the row stores and the free vector, walks the rows one per cycle
// during a check, buffers the safe sequence and hands it out one result
// beat at a time.
// ----------------------------------------------------------------------------
module bsc_back #(
    parameter int MAX_PROCS = bsc_pkg::MAX_PROCS_DEF,
    parameter int RESOURCES = bsc_pkg::RESOURCES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [bsc_pkg::PROCS_W-1:0]   i_cfg_data,
    output logic                          o_cfg_ready,
    input  bsc_pkg::t_cmd                 i_head,
    input  bsc_pkg::t_cmdq_status         i_q_status,
    output logic                          o_q_pop,
    input  logic                          i_pop,
    output logic                          o_empty,
    output logic                          o_safe_state,
    output logic [bsc_pkg::SEQ_W-1:0]     o_seq_process,
    output logic                          o_last_result
);

    localparam int ROW_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W  = $clog2(MAX_PROCS + 1);
    localparam int AMT_W  = bsc_pkg::AMT_W;
    localparam int WORK_W = bsc_pkg::WORK_W;

    bsc_pkg::t_back_state       r_state, n_state;
    logic [bsc_pkg::PROCS_W-1:0] r_procs;
    logic [AMT_W-1:0]           r_avail [RESOURCES];
    logic [AMT_W-1:0]           r_claim [MAX_PROCS][RESOURCES];
    logic [AMT_W-1:0]           r_alloc [MAX_PROCS][RESOURCES];
    logic [WORK_W-1:0]          r_work  [RESOURCES];
    logic [MAX_PROCS-1:0]       r_done;
    logic [ROW_W-1:0]           r_seq   [MAX_PROCS];
    logic [CNT_W-1:0]           r_count, n_count;
    logic [CNT_W-1:0]           r_n, n_n;
    logic [ROW_W-1:0]           r_p, n_p;
    logic [ROW_W-1:0]           r_k, n_k;
    logic                       r_found, n_found;
    logic                       r_unsafe, n_unsafe;

    logic                       w_avail_we;
    logic                       w_row_we;
    logic                       w_start;
    logic                       w_take;
    logic                       w_fits;
    logic                       w_last_row;
    logic                       w_last_out;
    logic [CNT_W-1:0]           w_count_inc;
    logic [CNT_W-1:0]           w_n_clamp;
    logic [ROW_W-1:0]           w_row_addr;
    logic [WORK_W-1:0]          w_work_sum [RESOURCES];

    assign o_cfg_ready = 1'b1;

    // Clamp the row count to 1 .. MAX_PROCS
    always_comb begin
        if (r_procs == '0) begin
            w_n_clamp = CNT_W'(1);
        end else if ({28'd0, r_procs} > 32'(MAX_PROCS)) begin
            w_n_clamp = CNT_W'(MAX_PROCS);
        end else begin
            w_n_clamp = CNT_W'(r_procs);
        end
    end

    // Test the current row against the working vector, form the new sums
    always_comb begin
        w_fits = 1'b1;
        for (int j = 0; j < RESOURCES; j++) begin
            if (r_claim[r_p][j] > r_alloc[r_p][j]) begin
                if ({{(WORK_W-AMT_W){1'b0}}, r_claim[r_p][j] - r_alloc[r_p][j]} > r_work[j]) begin
                    w_fits = 1'b0;
                end
            end
            w_work_sum[j] = bsc_pkg::sat_add(r_work[j], r_alloc[r_p][j]);
        end
    end

    assign w_take      = (r_state == bsc_pkg::ST_WALK) && !r_done[r_p] && w_fits;
    assign w_count_inc = r_count + CNT_W'(w_take);
    assign w_last_row  = (CNT_W'(r_p) == r_n - CNT_W'(1));
    assign w_last_out  = r_unsafe || (CNT_W'(r_k) == r_count - CNT_W'(1));
    assign w_row_addr  = ROW_W'(i_head.idx);

    // Sequence the walk: next state and handshakes
    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_n        = r_n;
        n_p        = r_p;
        n_k        = r_k;
        n_found    = r_found;
        n_unsafe   = r_unsafe;
        o_q_pop    = 1'b0;
        w_avail_we = 1'b0;
        w_row_we   = 1'b0;
        w_start    = 1'b0;
        case (r_state)
            bsc_pkg::ST_IDLE: begin
                if (!i_q_status.empty) begin
                    o_q_pop = 1'b1;
                    case (i_head.op)
                        bsc_pkg::FUNC_AVAIL: w_avail_we = 1'b1;
                        bsc_pkg::FUNC_ROW:   w_row_we   = 1'b1;
                        bsc_pkg::FUNC_CHECK: begin
                            w_start = 1'b1;
                            n_state = bsc_pkg::ST_WALK;
                            n_count = '0;
                            n_n     = w_n_clamp;
                            n_p     = '0;
                            n_found = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            bsc_pkg::ST_WALK: begin
                n_count = w_count_inc;
                n_found = r_found || w_take;
                if (w_count_inc == r_n) begin
                    n_state  = bsc_pkg::ST_EMIT;
                    n_unsafe = 1'b0;
                    n_k      = '0;
                end else if (w_last_row) begin
                    if (!(r_found || w_take)) begin
                        n_state  = bsc_pkg::ST_EMIT;
                        n_unsafe = 1'b1;
                        n_k      = '0;
                    end else begin
                        n_p     = '0;
                        n_found = 1'b0;
                    end
                end else begin
                    n_p = r_p + ROW_W'(1);
                end
            end
            bsc_pkg::ST_EMIT: begin
                if (i_pop) begin
                    if (w_last_out) begin
                        n_state = bsc_pkg::ST_IDLE;
                    end else begin
                        n_k = r_k + ROW_W'(1);
                    end
                end
            end
            default: n_state = bsc_pkg::ST_IDLE;
        endcase
    end

    // Control registers, free vector, working vector and finished flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= bsc_pkg::ST_IDLE;
            r_procs  <= bsc_pkg::PROCS_RESET;
            r_count  <= '0;
            r_n      <= '0;
            r_p      <= '0;
            r_k      <= '0;
            r_found  <= 1'b0;
            r_unsafe <= 1'b0;
            r_done   <= '0;
            for (int j = 0; j < RESOURCES; j++) begin
                r_avail[j] <= '0;
                r_work[j]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_n      <= n_n;
            r_p      <= n_p;
            r_k      <= n_k;
            r_found  <= n_found;
            r_unsafe <= n_unsafe;
            if (i_cfg_valid) begin
                r_procs <= i_cfg_data;
            end
            if (w_avail_we) begin
                for (int j = 0; j < RESOURCES; j++) begin
                    r_avail[j] <= i_head.amount[j];
                end
            end
            if (w_start) begin
                r_done <= '0;
                for (int j = 0; j < RESOURCES; j++) begin
                    r_work[j] <= {{(WORK_W-AMT_W){1'b0}}, r_avail[j]};
                end
            end else if (w_take) begin
                r_done[r_p] <= 1'b1;
                for (int j = 0; j < RESOURCES; j++) begin
                    r_work[j] <= w_work_sum[j];
                end
            end
        end
    end

    // Row stores and sequence buffer
    always_ff @(posedge i_clk) begin
        if (w_row_we) begin
            for (int j = 0; j < RESOURCES; j++) begin
                r_alloc[w_row_addr][j] <= i_head.amount[j];
                r_claim[w_row_addr][j] <= i_head.claim[j];
            end
        end
        if (w_take) begin
            r_seq[r_count[ROW_W-1:0]] <= r_p;
        end
    end

    // Present the result beat
    assign o_empty       = (r_state != bsc_pkg::ST_EMIT);
    assign o_safe_state  = !r_unsafe;
    assign o_seq_process = r_unsafe ? '0 : bsc_pkg::SEQ_W'(r_seq[r_k]);
    assign o_last_result = w_last_out;

    // Checks
    a_walk_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bsc_pkg::ST_WALK) |-> (r_count < r_n))
        else $error("walk count reached row count inside the walk");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_q_pop |-> (r_state == bsc_pkg::ST_IDLE))
        else $error("command popped while a check is running");

    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == bsc_pkg::ST_EMIT) && i_pop && w_last_out)
        |=> (r_state == bsc_pkg::ST_IDLE))
        else $error("check did not end after its last result beat");

    a_unsafe_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == bsc_pkg::ST_EMIT) && r_unsafe) |-> (r_count < r_n))
        else $error("unsafe result although every row finished");

    a_safe_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == bsc_pkg::ST_EMIT) && !r_unsafe) |-> (r_count == r_n))
        else $error("safe sequence shorter than the row count");

endmodule

@@ design/bankers_safety_check.sv @@
// Flow: a load enters the command queue and takes effect when the idle back pops it;
// a check starts when popped, walks one row per cycle for up to n passes of n rows
// (n = clamped procs_in_use), then one result beat per cycle while pop is held.
// Throughput: loads 1 per cycle while idle; checks are serialized by the row walk.
// Input is queued 4 deep, so items are taken while a check walks or results wait.
// Reset (synchronous, active low): command queue empty, free vector zero, procs_in_use 8.
// ----------------------------------------------------------------------------
// bankers_safety_check: deadlock-avoidance safety check
// Front classifies item beats, a command queue decouples it from the back,
// which holds the row stores and runs the safety walk.
// ----------------------------------------------------------------------------
module bankers_safety_check #(
    parameter int MAX_PROCS = bsc_pkg::MAX_PROCS_DEF,
    parameter int RESOURCES = bsc_pkg::RESOURCES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    input  logic [bsc_pkg::PROCS_W-1:0]   i_cfg_data,
    output logic                          o_cfg_ready,
    input  logic                          push,
    output logic                          full,
    input  logic [bsc_pkg::FUNC_W-1:0]    i_func,
    input  logic [bsc_pkg::IDX_W-1:0]     i_proc_index,
    input  logic [bsc_pkg::AMT_W-1:0]     i_amount_r0,
    input  logic [bsc_pkg::AMT_W-1:0]     i_amount_r1,
    input  logic [bsc_pkg::AMT_W-1:0]     i_amount_r2,
    input  logic [bsc_pkg::AMT_W-1:0]     i_amount_r3,
    input  logic [bsc_pkg::AMT_W-1:0]     i_claim_r0,
    input  logic [bsc_pkg::AMT_W-1:0]     i_claim_r1,
    input  logic [bsc_pkg::AMT_W-1:0]     i_claim_r2,
    input  logic [bsc_pkg::AMT_W-1:0]     i_claim_r3,
    output logic                          empty,
    input  logic                          pop,
    output logic                          o_safe_state,
    output logic [bsc_pkg::SEQ_W-1:0]     o_seq_process,
    output logic                          o_last_result
);

    bsc_pkg::t_cmdq_wr                                  w_wr;
    bsc_pkg::t_cmdq_status                              w_q_status;
    bsc_pkg::t_cmd                                      w_head;
    logic                                               w_q_pop;
    logic [bsc_pkg::LANES-1:0][bsc_pkg::AMT_W-1:0]      w_amount;
    logic [bsc_pkg::LANES-1:0][bsc_pkg::AMT_W-1:0]      w_claim;

    // Gather the resource lanes
    assign w_amount = {i_amount_r3, i_amount_r2, i_amount_r1, i_amount_r0};
    assign w_claim  = {i_claim_r3, i_claim_r2, i_claim_r1, i_claim_r0};
    assign full     = w_q_status.full;

    bsc_front #(
        .MAX_PROCS (MAX_PROCS)
    ) u_front (
        .push         (push),
        .i_q_status   (w_q_status),
        .i_func       (i_func),
        .i_proc_index (i_proc_index),
        .i_amount     (w_amount),
        .i_claim      (w_claim),
        .o_wr         (w_wr)
    );

    bsc_cmd_queue u_cmd_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (w_wr),
        .i_pop    (w_q_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    bsc_back #(
        .MAX_PROCS (MAX_PROCS),
        .RESOURCES (RESOURCES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .i_head        (w_head),
        .i_q_status    (w_q_status),
        .o_q_pop       (w_q_pop),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_safe_state  (o_safe_state),
        .o_seq_process (o_seq_process),
        .o_last_result (o_last_result)
    );

endmodule

@@ dv/tb_bankers_safety_check.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bankers_safety_check: self-checking bench for the banker's safety check
// A short directed plan of loads, checks and row-count settings runs first.
// Random load/check sequences follow, with random push and pop gaps. Each result
// beat is compared with the bench's walk model or a hand-written expectation.
// ----------------------------------------------------------------------------
module tb_bankers_safety_check;
    import bsc_pkg::*;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 11;
    localparam int NPROC       = MAX_PROCS_DEF;
    localparam int NRES        = RESOURCES_DEF;
    localparam int RAND_ITEMS  = 450;
    localparam int NUM_PHASES  = 7;
    localparam int SETTLE_CYC  = 40;
    localparam int TAIL_CYC    = 100;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYC    = 300;
    localparam int STALL_LIMIT = 4000;

    // Function code outside the defined set: the block drops it
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0]           func;
        logic [IDX_W-1:0]            idx;
        logic [LANES-1:0][AMT_W-1:0] amount;
        logic [LANES-1:0][AMT_W-1:0] claim;
    } t_req;

    typedef struct packed {
        logic             safe;
        logic [SEQ_W-1:0] proc;
        logic             last;
    } t_beat;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_IN_ORDER,
        STEP_UNSAFE,
        STEP_CFG
    } t_step_kind;

    typedef struct packed {
        t_step_kind kind;
        t_req       req;
    } t_step;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic [PROCS_W-1:0]   i_cfg_data;
    logic                 o_cfg_ready;
    logic                 push;
    logic                 full;
    logic                 empty;
    logic                 pop;
    logic                 o_safe_state;
    logic [SEQ_W-1:0]     o_seq_process;
    logic                 o_last_result;
    t_req                 cur_req;

    // Bench copy of the block state
    logic [AMT_W-1:0]     claim_tbl [NPROC][NRES];
    logic [AMT_W-1:0]     alloc_tbl [NPROC][NRES];
    logic [AMT_W-1:0]     free_vec [NRES];
    logic [PROCS_W-1:0]   procs_setting;
    t_beat                pending_beats [$];

    int unsigned          send_run;
    int unsigned          drain_run;
    int unsigned          bad_count;
    int unsigned          beats_checked;
    int unsigned          safe_beats;
    int unsigned          unsafe_beats;
    int unsigned          items_taken;
    int unsigned          checks_run;
    int unsigned          dropped_items;
    int unsigned          settings_used;
    int unsigned          stall_cycles;

    bankers_safety_check uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .push          (push),
        .full          (full),
        .i_func        (cur_req.func),
        .i_proc_index  (cur_req.idx),
        .i_amount_r0   (cur_req.amount[0]),
        .i_amount_r1   (cur_req.amount[1]),
        .i_amount_r2   (cur_req.amount[2]),
        .i_amount_r3   (cur_req.amount[3]),
        .i_claim_r0    (cur_req.claim[0]),
        .i_claim_r1    (cur_req.claim[1]),
        .i_claim_r2    (cur_req.claim[2]),
        .i_claim_r3    (cur_req.claim[3]),
        .empty         (empty),
        .pop           (pop),
        .o_safe_state  (o_safe_state),
        .o_seq_process (o_seq_process),
        .o_last_result (o_last_result)
    );

    // Free-running clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Row count after clamping to 1 .. NPROC
    function automatic int unsigned rows_active();
        if (procs_setting == 0) return 1;
        if (procs_setting > NPROC) return NPROC;
        return procs_setting;
    endfunction

    // Update the bench state for one item, queue the beats a check yields
    function automatic void apply_request(input t_req req);
        logic [WORK_W-1:0] work [NRES];
        logic [WORK_W:0]   sum;
        logic [NPROC-1:0]  done;
        int unsigned       order [NPROC];
        int unsigned       n;
        int unsigned       count;
        int                need;
        logic              progress;
        logic              fits;
        t_beat             b;
        case (req.func)
            FUNC_AVAIL: begin
                for (int j = 0; j < NRES; j++) free_vec[j] = req.amount[j];
            end
            FUNC_ROW: begin
                for (int j = 0; j < NRES; j++) begin
                    alloc_tbl[req.idx][j] = req.amount[j];
                    claim_tbl[req.idx][j] = req.claim[j];
                end
            end
            FUNC_CHECK: begin
                n = rows_active();
                count = 0;
                done = '0;
                progress = 1'b1;
                for (int j = 0; j < NRES; j++) work[j] = WORK_W'(free_vec[j]);
                // Passes in index order; a finished row grows the vector at once
                while (count < n && progress) begin
                    progress = 1'b0;
                    for (int p = 0; p < n; p++) begin
                        if (!done[p]) begin
                            fits = 1'b1;
                            for (int j = 0; j < NRES; j++) begin
                                need = int'(claim_tbl[p][j]) - int'(alloc_tbl[p][j]);
                                if (need > int'(work[j])) fits = 1'b0;
                            end
                            if (fits) begin
                                for (int j = 0; j < NRES; j++) begin
                                    sum = {1'b0, work[j]} + (WORK_W + 1)'(alloc_tbl[p][j]);
                                    work[j] = sum[WORK_W] ? {WORK_W{1'b1}} : sum[WORK_W-1:0];
                                end
                                order[count] = p;
                                count++;
                                done[p] = 1'b1;
                                progress = 1'b1;
                            end
                        end
                    end
                end
                if (count < n) begin
                    b.safe = 1'b0;
                    b.proc = '0;
                    b.last = 1'b1;
                    pending_beats.push_back(b);
                end else begin
                    for (int k = 0; k < count; k++) begin
                        b.safe = 1'b1;
                        b.proc = SEQ_W'(order[k]);
                        b.last = (k + 1 == count);
                        pending_beats.push_back(b);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Hand-written expectations for the directed checks
    function automatic void expect_typed(input t_step_kind kind);
        int unsigned n;
        t_beat       b;
        n = rows_active();
        if (kind == STEP_UNSAFE) begin
            b.safe = 1'b0;
            b.proc = '0;
            b.last = 1'b1;
            pending_beats.push_back(b);
        end else begin
            for (int k = 0; k < n; k++) begin
                b.safe = 1'b1;
                b.proc = SEQ_W'(k);
                b.last = (k + 1 == n);
                pending_beats.push_back(b);
            end
        end
    endfunction

    function automatic t_step st(input t_step_kind kind, input logic [FUNC_W-1:0] func,
                                 input logic [IDX_W-1:0] idx, input logic [31:0] amt,
                                 input logic [31:0] clm);
        t_step s;
        s.kind       = kind;
        s.req.func   = func;
        s.req.idx    = idx;
        s.req.amount = amt;
        s.req.claim  = clm;
        return s;
    endfunction

    // Item with every field random except the function code
    function automatic t_req noise_req(input logic [FUNC_W-1:0] func);
        t_req req;
        req.func   = func;
        req.idx    = IDX_W'($urandom);
        req.amount = $urandom;
        req.claim  = $urandom;
        return req;
    endfunction

    // Row load, mostly small allocations with a modest need, sometimes full range
    function automatic t_req random_row(input int unsigned n);
        t_req        req;
        int unsigned a;
        int unsigned c;
        logic        wide;
        req = noise_req(FUNC_ROW);
        if ($urandom_range(0, 4) != 0) req.idx = IDX_W'($urandom_range(0, n - 1));
        wide = ($urandom_range(0, 3) == 0);
        for (int j = 0; j < NRES; j++) begin
            if (!wide) begin
                a = $urandom_range(0, 31);
                if ($urandom_range(0, 9) == 0) c = a / 2;
                else c = a + $urandom_range(0, 40);
                req.amount[j] = AMT_W'(a);
                req.claim[j]  = (c > 255) ? 8'hff : AMT_W'(c);
            end
        end
        return req;
    endfunction

    function automatic t_req random_free();
        t_req req;
        req = noise_req(FUNC_AVAIL);
        if ($urandom_range(0, 3) != 0) begin
            for (int j = 0; j < NRES; j++) req.amount[j] = AMT_W'($urandom_range(0, 40));
        end
        return req;
    endfunction

    // Mostly short gaps, a few long ones, and now and then a run with none
    task automatic pick_gap(inout int unsigned run, output int unsigned gap);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (run != 0) begin
            run--;
            gap = 0;
        end else if (r < 4) begin
            run = $urandom_range(20, 60);
            gap = 0;
        end else if (r < 55) begin
            gap = 0;
        end else if (r < 92) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
    endtask

    // Offer one item beat, hold it until taken, then predict its results
    task automatic offer(input t_req req, input t_step_kind kind);
        int unsigned gap;
        pick_gap(send_run, gap);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        cur_req <= req;
        push    <= 1'b1;
        do @(posedge i_clk); while (full !== 1'b0);
        if (kind == STEP_ITEM) apply_request(req);
        else expect_typed(kind);
        if (req.func == FUNC_CHECK) checks_run++;
        if (req.func == FUNC_UNUSED) dropped_items++;
        items_taken++;
    endtask

    // Drain all results, then let queued loads land
    task automatic settle_idle();
        push <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_procs(input logic [PROCS_W-1:0] value);
        settle_idle();
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        i_cfg_valid <= 1'b0;
        procs_setting = value;
        settings_used++;
    endtask

    // Mostly well-formed load/check sequences, the rest noise and lone items
    task automatic random_phase(input int unsigned quota);
        int unsigned taken;
        int unsigned n;
        int unsigned r;
        t_req        req;
        taken = 0;
        while (taken < quota) begin
            n = rows_active();
            r = $urandom_range(0, 99);
            if (r < 85) begin
                repeat ($urandom_range(0, 3)) begin
                    offer(random_row(n), STEP_ITEM);
                    taken++;
                end
                if ($urandom_range(0, 9) < 7) begin
                    offer(random_free(), STEP_ITEM);
                    taken++;
                end
                offer(noise_req(FUNC_CHECK), STEP_ITEM);
                taken++;
            end else if (r < 93) begin
                offer(noise_req(FUNC_UNUSED), STEP_ITEM);
                taken++;
            end else begin
                req = ($urandom_range(0, 1) != 0) ? random_row(n) : random_free();
                offer(req, STEP_ITEM);
                taken++;
            end
        end
    endtask

    // Consumer: random pop gaps, one long hold-off once the run is under way
    initial begin : result_drain
        int unsigned gap;
        logic        held;
        held = 1'b0;
        pop <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            pick_gap(drain_run, gap);
            if (!held && beats_checked >= HOLD_AT) begin
                held = 1'b1;
                gap  = HOLD_CYC;
            end
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
        end
    end

    // Compare each popped beat with the oldest expectation
    always @(posedge i_clk) begin : beat_check
        t_beat want;
        if (i_rst_n === 1'b1 && pop === 1'b1 && empty === 1'b0) begin
            if (pending_beats.size() == 0) begin
                $error("unexpected result beat: safe_state %0d seq_process %0d last_result %0d",
                       o_safe_state, o_seq_process, o_last_result);
                bad_count++;
            end else begin
                want = pending_beats.pop_front();
                if (o_safe_state !== want.safe) begin
                    $error("safe_state: expected %0d, got %0d", want.safe, o_safe_state);
                    bad_count++;
                end
                if (o_seq_process !== want.proc) begin
                    $error("seq_process: expected %0d, got %0d", want.proc, o_seq_process);
                    bad_count++;
                end
                if (o_last_result !== want.last) begin
                    $error("last_result: expected %0d, got %0d", want.last, o_last_result);
                    bad_count++;
                end
                beats_checked++;
                if (want.safe) safe_beats++;
                else unsafe_beats++;
            end
        end
    end

    // Watchdog: end the run when no beat moves on any channel for too long
    always @(posedge i_clk) begin : stall_watch
        if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0) ||
            (i_cfg_valid === 1'b1 && o_cfg_ready === 1'b1)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("stalled for %0d cycles with %0d beats outstanding",
                     stall_cycles, pending_beats.size());
            $display("simulation failed");
            $finish;
        end
    end

    initial begin : main_seq
        t_step              plan [$];
        logic [PROCS_W-1:0] phase_procs [NUM_PHASES];
        logic [PROCS_W-1:0] value;
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= '0;
        cur_req     <= '0;
        procs_setting = PROCS_RESET;
        for (int j = 0; j < NRES; j++) free_vec[j] = '0;
        phase_procs = '{4'd3, 4'd8, 4'd2, 4'd15, 4'd6, 4'd0, 4'd5};
        send_run = 0;
        drain_run = 0;
        bad_count = 0;
        beats_checked = 0;
        safe_beats = 0;
        unsafe_beats = 0;
        items_taken = 0;
        checks_run = 0;
        dropped_items = 0;
        settings_used = 0;
        stall_cycles = 0;

        // Write every row first, all with zero or negative need
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd0, 32'h00000000, 32'h00000000));
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd1, 32'h01020304, 32'h01020304));
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd2, 32'h10203040, 32'h0f1f2f3f));
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd3, 32'hffffffff, 32'h00000000));
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd4, 32'h55aa55aa, 32'h55aa55aa));
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd5, 32'haa55aa55, 32'haa55aa55));
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd6, 32'h00000001, 32'h00000001));
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd7, 32'hffffffff, 32'hffffffff));
        plan.push_back(st(STEP_ITEM, FUNC_AVAIL, 3'd0, 32'h00000000, 32'h00000000));
        // Nothing needed: every row finishes in the first pass, in index order
        plan.push_back(st(STEP_IN_ORDER, FUNC_CHECK, 3'd0, 32'h00000000, 32'h00000000));
        // Row 0 claims the maximum; it only fits after others release
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd0, 32'h00000000, 32'hffffffff));
        plan.push_back(st(STEP_ITEM, FUNC_CHECK, 3'd7, 32'hffffffff, 32'hffffffff));
        // Single row with nothing free: unsafe
        plan.push_back(st(STEP_CFG, FUNC_AVAIL, 3'd0, 32'd1, 32'h0));
        plan.push_back(st(STEP_UNSAFE, FUNC_CHECK, 3'd0, 32'h00000000, 32'h00000000));
        plan.push_back(st(STEP_ITEM, FUNC_AVAIL, 3'd0, 32'hffffffff, 32'hffffffff));
        plan.push_back(st(STEP_IN_ORDER, FUNC_CHECK, 3'd0, 32'h00000000, 32'h00000000));
        plan.push_back(st(STEP_ITEM, FUNC_UNUSED, 3'd5, 32'h5aa5c33c, 32'hc33c5aa5));
        // Row count zero acts as one, fifteen acts as the full table
        plan.push_back(st(STEP_CFG, FUNC_AVAIL, 3'd0, 32'd0, 32'h0));
        plan.push_back(st(STEP_IN_ORDER, FUNC_CHECK, 3'd0, 32'h00000000, 32'h00000000));
        plan.push_back(st(STEP_CFG, FUNC_AVAIL, 3'd0, 32'd15, 32'h0));
        plan.push_back(st(STEP_ITEM, FUNC_AVAIL, 3'd0, 32'h00000000, 32'h00000000));
        plan.push_back(st(STEP_ITEM, FUNC_ROW, 3'd2, 32'h00ff00ff, 32'h80808080));
        plan.push_back(st(STEP_ITEM, FUNC_CHECK, 3'd0, 32'h00000000, 32'h00000000));
        // Everything free: every need fits on the first pass
        plan.push_back(st(STEP_ITEM, FUNC_AVAIL, 3'd0, 32'hffffffff, 32'h00000000));
        plan.push_back(st(STEP_IN_ORDER, FUNC_CHECK, 3'd0, 32'h00000000, 32'h00000000));

        repeat (RESET_CYC) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed plan
        foreach (plan[i]) begin
            if (plan[i].kind == STEP_CFG) write_procs(plan[i].req.amount[0][PROCS_W-1:0]);
            else offer(plan[i].req, plan[i].kind);
        end

        // Random phases, each under its own row count
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            value = (ph == NUM_PHASES - 1) ? PROCS_W'($urandom_range(0, 15)) : phase_procs[ph];
            write_procs(value);
            random_phase(RAND_ITEMS / NUM_PHASES);
        end

        // Drain, then a quiet tail to catch stray beats
        push <= 1'b0;
        while (pending_beats.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("covered %0d items (%0d with unused code), %0d checks, %0d row-count writes",
                 items_taken, dropped_items, checks_run, settings_used);
        $display("compared %0d result beats: %0d safe-sequence, %0d unsafe",
                 beats_checked, safe_beats, unsafe_beats);
        if (bad_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
